>>> design/masked_bitvector_projection_assert.svh
// Assertion macros used by the checker file of the projection block.
`ifndef MASKED_BITVECTOR_PROJECTION_ASSERT_SVH
`define MASKED_BITVECTOR_PROJECTION_ASSERT_SVH

// Checked on every rising edge, ignored while reset is high.
`define MBP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mbp assertion failed");

// Checked on every rising edge, reset included.
`define MBP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("mbp assertion failed");

`endif

>>> design/mbp_pkg.sv
// Shared constants, types and helper functions of the masked bit-vector projection.
`default_nettype none

package mbp_pkg;

   localparam int unsigned WORD_BITS   = 64;
   localparam int unsigned LANE_BITS   = 8;
   localparam int unsigned NUM_LANES   = WORD_BITS / LANE_BITS;
   localparam int unsigned COUNT_W     = 7;
   localparam int unsigned FILL_W      = 6;
   localparam int unsigned SUPPORT_W   = 17;
   localparam logic [SUPPORT_W-1:0] SUPPORT_MAX = 17'd65536;
   localparam logic [SUPPORT_W-1:0] MIN_SUPPORT_RESET = 17'd1;
   localparam logic [COUNT_W-1:0]   FULL_COUNT = 7'd64;

   // result queue; depth is a power of two so the pointers wrap by themselves
   localparam int unsigned FIFO_DEPTH = 8;
   localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam int unsigned REQ_DATA_W = 2 * WORD_BITS;
   localparam int unsigned RSP_DATA_W = 96;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - WORD_BITS - COUNT_W - SUPPORT_W - 1;

   // one extracted input word
   typedef struct packed {
      logic [WORD_BITS-1:0] bits;
      logic [COUNT_W-1:0]   cnt;
      logic [COUNT_W-1:0]   ones;
      logic                 last;
   } ext_type;

   // one result transaction
   typedef struct packed {
      logic [WORD_BITS-1:0] packed_word;
      logic [COUNT_W-1:0]   bit_count;
      logic [SUPPORT_W-1:0] support;
      logic                 frequent;
      logic                 last_result;
   } result_type;

   // up to two results written into the queue in one cycle
   typedef struct packed {
      logic       v0;
      logic       v1;
      result_type r0;
      result_type r1;
   } push_type;

   // bit extract within one byte lane
   function automatic logic [LANE_BITS-1:0] pext_lane(input logic [LANE_BITS-1:0] d,
                                                      input logic [LANE_BITS-1:0] m);
      logic [LANE_BITS-1:0] r;
      logic [3:0]           k;
      r = '0;
      k = '0;
      for (int b = 0; b < LANE_BITS; b++) begin
         if (m[b]) begin
            r[k[2:0]] = d[b];
            k = k + 4'd1;
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/mbp_extract.sv
// Parallel bit extract of one 64-bit word plus kept-bit and ones counts.
`default_nettype none

module mbp_extract (
   input  logic [mbp_pkg::WORD_BITS-1:0] mask_word,
   input  logic [mbp_pkg::WORD_BITS-1:0] data_word,
   input  logic                          last_word,
   output mbp_pkg::ext_type              ext
);

   logic [mbp_pkg::COUNT_W-1:0]   lane_cnt [mbp_pkg::NUM_LANES];
   logic [mbp_pkg::COUNT_W-1:0]   lane_off [mbp_pkg::NUM_LANES];
   logic [mbp_pkg::WORD_BITS-1:0] gathered;

   // each lane compacts on its own, then lands at the running sum of earlier lanes
   always_comb begin
      for (int i = 0; i < mbp_pkg::NUM_LANES; i++) begin
         lane_cnt[i] = mbp_pkg::COUNT_W'($countones(mask_word[i*mbp_pkg::LANE_BITS +:
                                                              mbp_pkg::LANE_BITS]));
      end
      lane_off[0] = '0;
      for (int i = 1; i < mbp_pkg::NUM_LANES; i++) begin
         lane_off[i] = lane_off[i-1] + lane_cnt[i-1];
      end
      gathered = '0;
      for (int i = 0; i < mbp_pkg::NUM_LANES; i++) begin
         gathered = gathered |
            ({{(mbp_pkg::WORD_BITS-mbp_pkg::LANE_BITS){1'b0}},
              mbp_pkg::pext_lane(data_word[i*mbp_pkg::LANE_BITS +: mbp_pkg::LANE_BITS],
                                 mask_word[i*mbp_pkg::LANE_BITS +: mbp_pkg::LANE_BITS])}
             << lane_off[i]);
      end
      ext.bits = gathered;
      ext.cnt  = lane_off[mbp_pkg::NUM_LANES-1] + lane_cnt[mbp_pkg::NUM_LANES-1];
      ext.ones = mbp_pkg::COUNT_W'($countones(mask_word & data_word));
      ext.last = last_word;
   end

endmodule

`default_nettype wire

>>> design/mbp_rsp_fifo.sv
// Result queue: takes up to two entries per cycle, gives one per cycle on pop.
`default_nettype none

module mbp_rsp_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  mbp_pkg::push_type              push,
   input  logic                           pop,
   output mbp_pkg::result_type            head,
   output logic                           not_empty,
   output logic [mbp_pkg::FIFO_CNT_W-1:0] count
);

   mbp_pkg::result_type              mem_ff [mbp_pkg::FIFO_DEPTH];
   logic [mbp_pkg::FIFO_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [mbp_pkg::FIFO_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [mbp_pkg::FIFO_CNT_W-1:0]   count_ff, count_in;
   logic [mbp_pkg::FIFO_PTR_W-1:0]   wr_ptr_p1;
   logic [mbp_pkg::FIFO_CNT_W-1:0]   n_push;

   assign wr_ptr_p1 = wr_ptr_ff + mbp_pkg::FIFO_PTR_W'(1);
   assign n_push    = mbp_pkg::FIFO_CNT_W'(push.v0) + mbp_pkg::FIFO_CNT_W'(push.v1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + mbp_pkg::FIFO_PTR_W'(n_push);
      rd_ptr_in = rd_ptr_ff + mbp_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + n_push - mbp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.v1) begin
         mem_ff[wr_ptr_p1] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

>>> design/masked_bitvector_projection.sv
// Top level: masked bit-vector projection (bit extract with dense 64-bit packing).
//
// channel  dir  handshake              payload
// -------  ---  ---------------------  ------------------------------------------------
// req      in   req_tvalid/req_tready  tdata: mask_word, data_word; tlast: last_word
// rsp      out  rsp_tvalid/rsp_tready  tdata: packed_word, bit_count, support, frequent;
//                                      tlast: last_result
// csr      in   csr_valid/csr_ready    csr_wdata: min_support (always ready)
//
// One word per cycle in while req_tready is high: input register -> extract register -> pack into the result queue.
// A result reaches rsp through the input register, the extract register and the result queue.
// A word gives 0, 1 or 2 results; sustained throughput is one result per cycle on rsp while rsp_tready is high.
// req_tready drops only when the 8-entry result queue could not take what is in flight plus a new word.
// Synchronous reset clears the pipeline, queue, pack state and sets min_support to 1.
`default_nettype none

module masked_bitvector_projection (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [63:0] mask_word, [127:64] data_word
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [mbp_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: [63:0] packed_word, [70:64] bit_count, [87:71] support,
   //            [88] frequent, [95:89] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [mbp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbp_pkg::SUPPORT_W-1:0]   csr_wdata
);

   // ---------------- configuration ----------------
   logic [mbp_pkg::SUPPORT_W-1:0] min_support_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_support_ff <= mbp_pkg::MIN_SUPPORT_RESET;
      end else if (csr_valid && csr_ready) begin
         min_support_ff <= csr_wdata;
      end
   end

   // ---------------- stage 0: input register ----------------
   logic                          req_fire;
   logic                          s0_valid_ff;
   logic [mbp_pkg::WORD_BITS-1:0] s0_mask_ff, s0_data_ff;
   logic                          s0_last_ff;

   assign req_fire = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_mask_ff <= req_tdata[mbp_pkg::WORD_BITS-1:0];
         s0_data_ff <= req_tdata[mbp_pkg::REQ_DATA_W-1:mbp_pkg::WORD_BITS];
         s0_last_ff <= req_tlast;
      end
   end

   // ---------------- stage 1: extract ----------------
   mbp_pkg::ext_type ext_in;
   mbp_pkg::ext_type s1_ext_ff;
   logic             s1_valid_ff;

   mbp_extract u_extract (
      .mask_word (s0_mask_ff),
      .data_word (s0_data_ff),
      .last_word (s0_last_ff),
      .ext       (ext_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_valid_ff) begin
         s1_ext_ff <= ext_in;
      end
   end

   // ---------------- stage 2: pack into 64-bit words ----------------
   // pack_buffer keeps only its low fill_level bits nonzero.
   logic [mbp_pkg::WORD_BITS-1:0]   pack_buffer_ff, pack_buffer_in;
   logic [mbp_pkg::FILL_W-1:0]      fill_level_ff, fill_level_in;
   logic [mbp_pkg::SUPPORT_W-1:0]   support_ff, support_in;

   logic [mbp_pkg::COUNT_W-1:0]     total;
   logic [2*mbp_pkg::WORD_BITS-1:0] shifted;
   logic [mbp_pkg::WORD_BITS-1:0]   merged;
   logic                            full_word;
   logic [mbp_pkg::SUPPORT_W:0]     support_sum;
   logic [mbp_pkg::SUPPORT_W-1:0]   support_new;
   logic                            frequent;
   logic [mbp_pkg::WORD_BITS-1:0]   rest_buffer;
   logic [mbp_pkg::FILL_W-1:0]      rest_fill;
   mbp_pkg::result_type             full_res, flush_res;
   mbp_pkg::push_type               push;

   always_comb begin
      total     = {1'b0, fill_level_ff} + s1_ext_ff.cnt;
      shifted   = {{mbp_pkg::WORD_BITS{1'b0}}, s1_ext_ff.bits} << fill_level_ff;
      merged    = pack_buffer_ff | shifted[mbp_pkg::WORD_BITS-1:0];
      // total never reaches 128, so bit 6 alone means a full word
      full_word = total[mbp_pkg::COUNT_W-1];

      // spill bits after a full word, else the merged partial word
      rest_buffer = full_word ? shifted[2*mbp_pkg::WORD_BITS-1:mbp_pkg::WORD_BITS] : merged;
      rest_fill   = total[mbp_pkg::FILL_W-1:0];

      // saturating support count
      support_sum = {1'b0, support_ff} +
                    {{(mbp_pkg::SUPPORT_W+1-mbp_pkg::COUNT_W){1'b0}}, s1_ext_ff.ones};
      support_new = (support_sum > {1'b0, mbp_pkg::SUPPORT_MAX}) ?
                    mbp_pkg::SUPPORT_MAX : support_sum[mbp_pkg::SUPPORT_W-1:0];
      frequent    = (support_new >= min_support_ff);

      full_res.packed_word = merged;
      full_res.bit_count   = mbp_pkg::FULL_COUNT;
      full_res.support     = support_new;
      full_res.frequent    = frequent;
      full_res.last_result = s1_ext_ff.last && (rest_fill == '0);

      flush_res.packed_word = rest_buffer;
      flush_res.bit_count   = {1'b0, rest_fill};
      flush_res.support     = support_new;
      flush_res.frequent    = frequent;
      flush_res.last_result = 1'b1;

      // full word first; a flush follows on the last word when bits remain,
      // or stands alone (possibly empty) when no full word was made
      push.v0 = s1_valid_ff && (full_word || s1_ext_ff.last);
      push.r0 = full_word ? full_res : flush_res;
      push.v1 = s1_valid_ff && full_word && s1_ext_ff.last && (rest_fill != '0);
      push.r1 = flush_res;

      pack_buffer_in = pack_buffer_ff;
      fill_level_in  = fill_level_ff;
      support_in     = support_ff;
      if (s1_valid_ff) begin
         if (s1_ext_ff.last) begin
            // end of vector: start the next one clean
            pack_buffer_in = '0;
            fill_level_in  = '0;
            support_in     = '0;
         end else begin
            pack_buffer_in = rest_buffer;
            fill_level_in  = rest_fill;
            support_in     = support_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_buffer_ff <= '0;
         fill_level_ff  <= '0;
         support_ff     <= '0;
      end else begin
         pack_buffer_ff <= pack_buffer_in;
         fill_level_ff  <= fill_level_in;
         support_ff     <= support_in;
      end
   end

   // ---------------- result queue ----------------
   mbp_pkg::result_type            head;
   logic                           q_not_empty;
   logic [mbp_pkg::FIFO_CNT_W-1:0] q_count;
   logic                           rsp_fire;
   logic [mbp_pkg::FIFO_CNT_W:0]   committed;

   assign rsp_fire = rsp_tvalid && rsp_tready;

   mbp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_fire),
      .head      (head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // every word in flight may still need two slots; accept only if a new one fits too
   always_comb begin
      committed  = {1'b0, q_count} +
                   (mbp_pkg::FIFO_CNT_W+1)'(2 * (32'(s0_valid_ff) + 32'(s1_valid_ff)));
      req_tready = (committed <= (mbp_pkg::FIFO_CNT_W+1)'(mbp_pkg::FIFO_DEPTH - 2));
   end

   assign rsp_tvalid = q_not_empty;
   assign rsp_tdata  = {{mbp_pkg::RSP_PAD_W{1'b0}}, head.frequent, head.support,
                        head.bit_count, head.packed_word};
   assign rsp_tlast  = head.last_result;

endmodule

`default_nettype wire

>>> design/mbp_checker.sv
// Port-level checks of the projection block, bound to the top level.
`default_nettype none

`include "masked_bitvector_projection_assert.svh"

module mbp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mbp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);

   logic                          rsp_stall;
   logic [mbp_pkg::RSP_DATA_W:0]  rsp_beat;
   logic [mbp_pkg::WORD_BITS-1:0] rsp_word;
   logic [mbp_pkg::COUNT_W-1:0]   rsp_count;

   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_beat  = {rsp_tlast, rsp_tdata};
   assign rsp_word  = rsp_tdata[mbp_pkg::WORD_BITS-1:0];
   assign rsp_count = rsp_tdata[mbp_pkg::WORD_BITS +: mbp_pkg::COUNT_W];

   // stalled result holds
   `MBP_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_beat))
   // bit count never beyond one word
   `MBP_ASSERT(a_count_range, clock, reset, rsp_tvalid |-> rsp_count <= mbp_pkg::FULL_COUNT)
   // bits past the valid count are zero
   `MBP_ASSERT(a_clean_tail, clock, reset, rsp_tvalid |-> (rsp_word >> rsp_count) == 64'd0)
   // only the closing result of a vector may be partial
   `MBP_ASSERT(a_partial_last, clock, reset, rsp_stall || rsp_tvalid && !rsp_tlast |-> rsp_tlast || rsp_count == mbp_pkg::FULL_COUNT)
   // nothing comes out right after reset
   `MBP_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid)

endmodule

bind masked_bitvector_projection mbp_checker u_mbp_checker (.*);

`default_nettype wire
